// File: src/pba_pkg.sv
// Shared types, codes and defaults for the paged bump allocator.
// No dependencies; pba_ctrl, pba_dp and the top level refer to this package by scoped names.
package pba_pkg;

  localparam int PAGE_BYTES_DEF = 4096;
  localparam int MAX_PAGES_DEF  = 64;

  typedef logic [12:0] size_t;
  typedef logic [5:0]  page_idx_t;
  typedef logic [11:0] byte_off_t;
  typedef logic [6:0]  pages_t;
  typedef logic [11:0] cfg_data_t;

  typedef enum logic [1:0] {
    ST_GRANT     = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_PAGE   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_MISS_LIMIT = 2'd0,
    CFG_ALIGN_LOG2 = 2'd1,
    CFG_PAGE_HDR   = 2'd2,
    CFG_FIRST_HDR  = 2'd3
  } cfg_idx_t;

  localparam logic [7:0]  MISS_LIMIT_RST = 8'd4;
  localparam logic [2:0]  ALIGN_LOG2_RST = 3'd3;
  localparam logic [11:0] PAGE_HDR_RST   = 12'd32;
  localparam logic [11:0] FIRST_HDR_RST  = 12'd96;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EVAL,
    S_OPEN,
    S_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic init;
    logic accept;
    logic eval;
    logic open_pg;
    logic emit;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic too_large;
    logic walk_ok;
    logic fit;
    logic more;
    logic out_free;
  } stat_t;

endpackage

// File: src/paged_bump_allocator.sv
// Top level of the paged bump allocator: controller plus datapath.
// Depends on pba_pkg, pba_ctrl, pba_dp (which holds two pba_ram instances).
//
//   Channel  Handshake            Payload
//   in_      in_valid/in_ready    in_alloc_size
//   out_     out_valid/out_ready  out_status, out_page_index, out_byte_offset,
//                                 out_pages_in_use
//   cfg_     cfg_we               cfg_index, cfg_wdata
//
// An item is walked in the eval state, moves to the open state when no opened page
// fits, and goes straight to the done state when it is too large.
// The walk tests one opened page per cycle against the fill-offset RAM read port.
// After reset the init state writes page 0's fill offset and miss count; in_ready is low.
// A new item is taken while a finished result waits in the output register; a
// stalled output holds the next result back in the controller's done state.
module paged_bump_allocator #(
  parameter int PAGE_BYTES = pba_pkg::PAGE_BYTES_DEF,
  parameter int MAX_PAGES  = pba_pkg::MAX_PAGES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  pba_pkg::cfg_data_t  cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  pba_pkg::size_t      in_alloc_size,
  output logic                out_valid,
  input  logic                out_ready,
  output pba_pkg::status_t    out_status,
  output pba_pkg::page_idx_t  out_page_index,
  output pba_pkg::byte_off_t  out_byte_offset,
  output pba_pkg::pages_t     out_pages_in_use
);

  pba_pkg::cmd_t  cmd;
  pba_pkg::stat_t stat;

  pba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pba_dp #(
    .PAGE_BYTES (PAGE_BYTES),
    .MAX_PAGES  (MAX_PAGES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_alloc_size    (in_alloc_size),
    .out_ready        (out_ready),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_page_index   (out_page_index),
    .out_byte_offset  (out_byte_offset),
    .out_pages_in_use (out_pages_in_use)
  );

endmodule

// File: src/pba_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the per-page fill offsets and miss counts.
module pba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/pba_ctrl.sv
// Sequencing state machine of the paged bump allocator.
// Depends on pba_pkg; drives the datapath through cmd_t and reads stat_t.
module pba_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pba_pkg::stat_t  stat,
  output pba_pkg::cmd_t   cmd
);

  pba_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pba_pkg::S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pba_pkg::S_INIT: state_nxt = pba_pkg::S_IDLE;
      pba_pkg::S_IDLE: begin
        if (in_valid) begin
          priority if (stat.too_large) state_nxt = pba_pkg::S_DONE;
          else if (stat.walk_ok)       state_nxt = pba_pkg::S_EVAL;
          else                         state_nxt = pba_pkg::S_OPEN;
        end
      end
      pba_pkg::S_EVAL: begin
        priority if (stat.fit) state_nxt = pba_pkg::S_DONE;
        else if (stat.more)    state_nxt = pba_pkg::S_EVAL;
        else                   state_nxt = pba_pkg::S_OPEN;
      end
      pba_pkg::S_OPEN: state_nxt = pba_pkg::S_DONE;
      pba_pkg::S_DONE: begin
        if (stat.out_free) begin
          state_nxt = pba_pkg::S_IDLE;
        end
      end
      default: state_nxt = pba_pkg::S_INIT;
    endcase
  end

  always_comb begin
    in_ready    = (state_r == pba_pkg::S_IDLE);
    cmd.init    = (state_r == pba_pkg::S_INIT);
    cmd.accept  = (state_r == pba_pkg::S_IDLE) && in_valid;
    cmd.eval    = (state_r == pba_pkg::S_EVAL);
    cmd.open_pg = (state_r == pba_pkg::S_OPEN);
    cmd.emit    = (state_r == pba_pkg::S_DONE) && stat.out_free;
  end

endmodule

// File: src/pba_dp.sv
// Datapath of the paged bump allocator: registers, page RAMs, fit tests, result.
// Depends on pba_pkg and pba_ram; sequenced by pba_ctrl.
module pba_dp #(
  parameter int PAGE_BYTES = pba_pkg::PAGE_BYTES_DEF,
  parameter int MAX_PAGES  = pba_pkg::MAX_PAGES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  pba_pkg::cfg_data_t  cfg_wdata,
  input  pba_pkg::size_t      in_alloc_size,
  input  logic                out_ready,
  input  pba_pkg::cmd_t       cmd,
  output pba_pkg::stat_t      stat,
  output logic                out_valid,
  output pba_pkg::status_t    out_status,
  output pba_pkg::page_idx_t  out_page_index,
  output pba_pkg::byte_off_t  out_byte_offset,
  output pba_pkg::pages_t     out_pages_in_use
);

  localparam int AW    = $clog2(MAX_PAGES);
  localparam int TW    = $clog2(MAX_PAGES + 1);
  localparam int PBW   = $clog2(PAGE_BYTES + 1);
  // Offsets must hold a 12-bit header rounded up by up to 127 bytes.
  localparam int OFF_W = (PBW > 13) ? PBW : 13;
  localparam int RW    = OFF_W + 1;

  function automatic logic [RW-1:0] round_up(input logic [RW-1:0] x, input logic [2:0] sh);
    logic [RW-1:0] m;
    m = ~({RW{1'b1}} << sh);
    return (x + m) & ~m;
  endfunction

  // Configuration registers.
  logic [7:0]  miss_limit_r;
  logic [2:0]  align_r;
  logic [11:0] page_hdr_r;
  logic [11:0] first_hdr_r;

  // Allocator state.
  logic [AW-1:0] cur_r;
  logic          cur_valid_r;
  logic [TW-1:0] total_r;

  // Per-item working registers.
  pba_pkg::size_t     size_r;
  logic [AW-1:0]      p_r;
  pba_pkg::status_t   res_status_r;
  logic [AW-1:0]      res_page_r;
  pba_pkg::byte_off_t res_off_r;

  // Output register.
  logic               out_valid_r;
  pba_pkg::status_t   out_status_r;
  pba_pkg::page_idx_t out_page_r;
  pba_pkg::byte_off_t out_off_r;
  pba_pkg::pages_t    out_pages_r;

  // RAM ports.
  logic             fill_we, miss_we;
  logic [AW-1:0]    fill_waddr, miss_waddr, rd_addr;
  logic [OFF_W-1:0] fill_wdata, fill_rdata;
  logic [7:0]       miss_wdata, miss_rdata;

  logic [RW-1:0] pos_walk, end_walk, pos_open, end_open;
  logic          fit, open_fits, skip, more, full, open_ok;
  logic [7:0]    miss_inc;

  always_comb begin
    pos_walk  = round_up(RW'(fill_rdata), align_r);
    end_walk  = pos_walk + RW'(size_r);
    fit       = end_walk <= RW'(PAGE_BYTES);
    pos_open  = round_up(RW'(page_hdr_r), align_r);
    end_open  = pos_open + RW'(size_r);
    open_fits = end_open <= RW'(PAGE_BYTES);
    miss_inc  = (miss_rdata != 8'hFF) ? miss_rdata + 8'd1 : miss_rdata;
    skip      = miss_inc >= miss_limit_r;
    more      = (TW'(p_r) + TW'(1)) < total_r;
    full      = total_r >= TW'(MAX_PAGES);
    open_ok   = !full && open_fits;

    stat.too_large = (RW'(in_alloc_size) + RW'(page_hdr_r)) > RW'(PAGE_BYTES);
    stat.walk_ok   = cur_valid_r && (TW'(cur_r) < total_r);
    stat.fit       = fit;
    stat.more      = more;
    stat.out_free  = !out_valid_r || out_ready;
  end

  // While walking, the next page is read ahead so that one page is tested per cycle.
  assign rd_addr = cmd.eval ? (p_r + AW'(1)) : cur_r;

  always_comb begin
    fill_we    = 1'b0;
    fill_waddr = '0;
    fill_wdata = OFF_W'(first_hdr_r);
    priority if (cfg_we && cfg_index == pba_pkg::CFG_FIRST_HDR) begin
      fill_we    = 1'b1;
      fill_wdata = OFF_W'(cfg_wdata);
    end else if (cmd.init) begin
      fill_we    = 1'b1;
    end else if (cmd.eval && fit) begin
      fill_we    = 1'b1;
      fill_waddr = p_r;
      fill_wdata = OFF_W'(end_walk);
    end else if (cmd.open_pg && open_ok) begin
      fill_we    = 1'b1;
      fill_waddr = AW'(total_r);
      fill_wdata = OFF_W'(end_open);
    end
  end

  always_comb begin
    miss_we    = 1'b0;
    miss_waddr = '0;
    miss_wdata = '0;
    priority if (cmd.init) begin
      miss_we    = 1'b1;
    end else if (cmd.eval && !fit) begin
      miss_we    = 1'b1;
      miss_waddr = p_r;
      miss_wdata = miss_inc;
    end else if (cmd.open_pg && open_ok) begin
      miss_we    = 1'b1;
      miss_waddr = AW'(total_r);
    end
  end

  pba_ram #(.WIDTH(OFF_W), .DEPTH(MAX_PAGES)) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .raddr (rd_addr),
    .rdata (fill_rdata)
  );

  pba_ram #(.WIDTH(8), .DEPTH(MAX_PAGES)) u_miss_ram (
    .clk   (clk),
    .we    (miss_we),
    .waddr (miss_waddr),
    .wdata (miss_wdata),
    .raddr (rd_addr),
    .rdata (miss_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      miss_limit_r <= pba_pkg::MISS_LIMIT_RST;
      align_r      <= pba_pkg::ALIGN_LOG2_RST;
      page_hdr_r   <= pba_pkg::PAGE_HDR_RST;
      first_hdr_r  <= pba_pkg::FIRST_HDR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pba_pkg::CFG_MISS_LIMIT: miss_limit_r <= cfg_wdata[7:0];
        pba_pkg::CFG_ALIGN_LOG2: align_r      <= cfg_wdata[2:0];
        pba_pkg::CFG_PAGE_HDR:   page_hdr_r   <= cfg_wdata;
        pba_pkg::CFG_FIRST_HDR:  first_hdr_r  <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      cur_valid_r <= 1'b1;
      total_r     <= TW'(1);
    end else begin
      if (cmd.eval && !fit && skip) begin
        if (more) begin
          cur_r <= p_r + AW'(1);
        end else begin
          cur_valid_r <= 1'b0;
        end
      end
      if (cmd.open_pg && open_ok) begin
        total_r <= total_r + TW'(1);
        if (!cur_valid_r) begin
          cur_r       <= AW'(total_r);
          cur_valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      size_r       <= in_alloc_size;
      p_r          <= cur_r;
      res_status_r <= pba_pkg::ST_TOO_LARGE;
      res_page_r   <= '0;
      res_off_r    <= '0;
    end else if (cmd.eval) begin
      if (fit) begin
        res_status_r <= pba_pkg::ST_GRANT;
        res_page_r   <= p_r;
        res_off_r    <= pba_pkg::byte_off_t'(pos_walk);
      end else begin
        p_r <= p_r + AW'(1);
      end
    end else if (cmd.open_pg) begin
      priority if (full) begin
        res_status_r <= pba_pkg::ST_NO_PAGE;
      end else if (!open_fits) begin
        res_status_r <= pba_pkg::ST_TOO_LARGE;
      end else begin
        res_status_r <= pba_pkg::ST_GRANT;
        res_page_r   <= AW'(total_r);
        res_off_r    <= pba_pkg::byte_off_t'(pos_open);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_page_r   <= pba_pkg::page_idx_t'(res_page_r);
      out_off_r    <= res_off_r;
      out_pages_r  <= pba_pkg::pages_t'(total_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_page_index   = out_page_r;
  assign out_byte_offset  = out_off_r;
  assign out_pages_in_use = out_pages_r;

endmodule

// File: dv/tb_paged_bump_allocator.sv
`timescale 1ns / 1ps
// Self-checking testbench for paged_bump_allocator: a queue-fed driver, a ready driver and a
// result checker, with an allocation predictor kept beside them. Depends on pba_pkg and the RTL.
module tb_paged_bump_allocator;

  localparam int PAGE_BYTES = pba_pkg::PAGE_BYTES_DEF;
  localparam int MAX_PAGES  = pba_pkg::MAX_PAGES_DEF;

  typedef struct packed {
    pba_pkg::status_t   status;
    pba_pkg::page_idx_t page;
    pba_pkg::byte_off_t offset;
    pba_pkg::pages_t    pages;
  } alloc_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  pba_pkg::cfg_idx_t   cfg_index = pba_pkg::CFG_MISS_LIMIT;
  pba_pkg::cfg_data_t  cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  pba_pkg::size_t      in_alloc_size = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  pba_pkg::status_t    out_status;
  pba_pkg::page_idx_t  out_page_index;
  pba_pkg::byte_off_t  out_byte_offset;
  pba_pkg::pages_t     out_pages_in_use;

  paged_bump_allocator u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_alloc_size    (in_alloc_size),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_page_index   (out_page_index),
    .out_byte_offset  (out_byte_offset),
    .out_pages_in_use (out_pages_in_use)
  );

  always #2 clk = ~clk;

  // Predicted allocator state and register copies.
  logic [12:0] fill_at [MAX_PAGES];
  logic [7:0]  misses [MAX_PAGES];
  logic [5:0]  cur_page;
  logic        cur_ok;
  logic [6:0]  opened;
  logic [7:0]  skip_after;
  logic [2:0]  align_shift;
  logic [11:0] hdr_bytes;

  pba_pkg::size_t pending_sizes[$];
  alloc_result_t  expected_results[$];

  logic no_gaps = 1'b0;
  logic hold_wanted = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   mismatch_count = 0;
  int   result_count = 0;
  int   grant_count = 0;
  int   too_large_count = 0;
  int   no_page_count = 0;
  int   settings_used = 1;

  function automatic int unsigned align_up(input int unsigned x);
    int unsigned m;
    m = (32'd1 << align_shift) - 32'd1;
    return (x + m) & ~m;
  endfunction

  // Walks the opened pages from the current one; opens a page when none fits.
  function automatic alloc_result_t predict_alloc(input int unsigned size);
    alloc_result_t r;
    int unsigned   pos;
    int            p;
    r.status = pba_pkg::ST_TOO_LARGE;
    r.page   = '0;
    r.offset = '0;
    r.pages  = opened;
    if (size + hdr_bytes > PAGE_BYTES) return r;
    if (cur_ok && cur_page < opened) begin
      for (p = cur_page; p < opened && p < MAX_PAGES; p++) begin
        pos = align_up(fill_at[p]);
        if (pos + size <= PAGE_BYTES) begin
          fill_at[p] = 13'(pos + size);
          r.status = pba_pkg::ST_GRANT;
          r.page   = 6'(p);
          r.offset = 12'(pos);
          return r;
        end
        if (misses[p] != 8'd255) misses[p] = misses[p] + 8'd1;
        if (misses[p] >= skip_after) begin
          if (p + 1 < opened) cur_page = 6'(p + 1);
          else cur_ok = 1'b0;
        end
      end
    end
    if (opened >= MAX_PAGES) begin
      r.status = pba_pkg::ST_NO_PAGE;
      return r;
    end
    pos = align_up(hdr_bytes);
    if (pos + size > PAGE_BYTES) return r;
    fill_at[opened] = 13'(pos + size);
    misses[opened] = '0;
    r.status = pba_pkg::ST_GRANT;
    r.page   = opened[5:0];
    r.offset = 12'(pos);
    opened = opened + 7'd1;
    r.pages = opened;
    if (!cur_ok) begin
      cur_page = r.page;
      cur_ok = 1'b1;
    end
    return r;
  endfunction

  // Sender: offers queued sizes, with random gaps unless no_gaps is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(predict_alloc(in_alloc_size));
      if (!in_valid || in_ready) begin
        if (pending_sizes.size() != 0 && (no_gaps || $urandom_range(99) >= 22)) begin
          in_valid <= 1'b1;
          in_alloc_size <= pending_sizes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness, including one long hold-off while the sender keeps offering.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_wanted && !hold_done) begin
      hold_left = 400;
      hold_done = 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_gaps || $urandom_range(99) >= 22;
    end
  end

  always @(posedge clk) begin : check_results
    alloc_result_t got;
    alloc_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got.status = out_status;
      got.page   = out_page_index;
      got.offset = out_byte_offset;
      got.pages  = out_pages_in_use;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status %0d page %0d offset %0d pages %0d",
                   got.status, got.page, got.offset, got.pages);
      end else begin
        want = expected_results.pop_front();
        result_count++;
        if (got.status !== want.status || got.page !== want.page ||
            got.offset !== want.offset || got.pages !== want.pages) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"result %0d: expected status %0d page %0d offset %0d pages %0d,",
                      " got %0d %0d %0d %0d"},
                     result_count, want.status, want.page, want.offset, want.pages,
                     got.status, got.page, got.offset, got.pages);
        end
        case (want.status)
          pba_pkg::ST_GRANT:     grant_count++;
          pba_pkg::ST_TOO_LARGE: too_large_count++;
          default:               no_page_count++;
        endcase
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_sizes.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic write_reg(input pba_pkg::cfg_idx_t idx, input pba_pkg::cfg_data_t raw);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= raw;
    case (idx)
      pba_pkg::CFG_MISS_LIMIT: skip_after = raw[7:0];
      pba_pkg::CFG_ALIGN_LOG2: align_shift = raw[2:0];
      pba_pkg::CFG_PAGE_HDR:   hdr_bytes = raw;
      pba_pkg::CFG_FIRST_HDR:  fill_at[0] = {1'b0, raw};
    endcase
  endtask

  // Registers change only once every outstanding result has come back.
  task automatic set_registers(input pba_pkg::cfg_data_t ml, input pba_pkg::cfg_data_t al,
                               input pba_pkg::cfg_data_t ph, input pba_pkg::cfg_data_t fh);
    wait_drained();
    write_reg(pba_pkg::CFG_MISS_LIMIT, ml);
    write_reg(pba_pkg::CFG_ALIGN_LOG2, al);
    write_reg(pba_pkg::CFG_PAGE_HDR, ph);
    write_reg(pba_pkg::CFG_FIRST_HDR, fh);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Mostly small requests so that the pages last; a few large and oversized ones.
  task automatic queue_random(input int count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 85) pending_sizes.push_back(pba_pkg::size_t'($urandom_range(32)));
      else if (pick < 95) pending_sizes.push_back(pba_pkg::size_t'($urandom_range(256, 33)));
      else if (pick < 98)
        pending_sizes.push_back(pba_pkg::size_t'($urandom_range(2048, 257)));
      else if (pick == 98)
        pending_sizes.push_back(pba_pkg::size_t'(PAGE_BYTES - hdr_bytes + $urandom_range(1)));
      else pending_sizes.push_back(pba_pkg::size_t'($urandom_range(8191, 4097)));
    end
  endtask

  task automatic queue_list(input int unsigned sizes[]);
    foreach (sizes[i]) pending_sizes.push_back(pba_pkg::size_t'(sizes[i]));
  endtask

  initial begin
    foreach (fill_at[i]) begin
      fill_at[i] = '0;
      misses[i] = '0;
    end
    skip_after  = pba_pkg::MISS_LIMIT_RST;
    align_shift = pba_pkg::ALIGN_LOG2_RST;
    hdr_bytes   = pba_pkg::PAGE_HDR_RST;
    fill_at[0]  = {1'b0, pba_pkg::FIRST_HDR_RST};
    cur_page = '0;
    cur_ok   = 1'b1;
    opened   = 7'd1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: size extremes, alternating bit patterns, boundary of the header rule.
    queue_list('{0, 1, 0, 7, 8, 8191, 4065, 4064, 4096, 5461, 2730, 3000, 3000,
                 1500, 2000, 64, 63, 4000, 4064, 5});
    queue_random(200);
    // The sender stops here until everything outstanding has returned.
    wait_drained();
    queue_random(200);

    // Zero miss limit, byte alignment, no headers; page 0 is reloaded empty.
    set_registers(12'd0, 12'd0, 12'd0, 12'd0);
    no_gaps = 1'b1;
    queue_list('{4096, 4096, 0, 1});
    queue_random(300);
    wait_drained();
    no_gaps = 1'b0;

    // Widest alignment and largest headers: a new page's aligned header leaves room only for zero-byte requests.
    set_registers(12'd255, 12'd7, 12'd4095, 12'd4095);
    queue_list('{0, 1, 2, 1, 0});
    repeat (35) begin
      case ($urandom_range(3))
        0: pending_sizes.push_back(pba_pkg::size_t'(0));
        1: pending_sizes.push_back(pba_pkg::size_t'(1));
        2: pending_sizes.push_back(pba_pkg::size_t'(2));
        default: pending_sizes.push_back(pba_pkg::size_t'(8191));
      endcase
    end

    // A 33-byte header rounds up to 64, so a request of 4063 passes the size check only.
    set_registers(pba_pkg::cfg_data_t'($urandom_range(8, 1)), 12'd6, 12'd33,
                  pba_pkg::cfg_data_t'($urandom_range(4095)));
    queue_list('{4063, 4063, 64});
    queue_random(400);

    // Random raw register values, with unused upper data bits set as well.
    set_registers(pba_pkg::cfg_data_t'($urandom_range(4095)),
                  pba_pkg::cfg_data_t'($urandom_range(4095)),
                  pba_pkg::cfg_data_t'($urandom_range(600)),
                  pba_pkg::cfg_data_t'($urandom_range(4095)));
    hold_wanted = 1'b1;
    queue_random(400);

    // Large requests use up the remaining pages until the allocator runs out.
    set_registers(12'd2, 12'd2, 12'd100, 12'd200);
    repeat (80) pending_sizes.push_back(pba_pkg::size_t'($urandom_range(3996, 2000)));
    queue_random(150);

    wait_drained();
    repeat (40) @(posedge clk);
    $display("Checked %0d results over %0d register settings with %0d pages opened.",
             result_count, settings_used, opened);
    $display("Outcomes: %0d granted, %0d too large, %0d out of pages.",
             grant_count, too_large_count, no_page_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb_paged_bump_allocator: done, clean");
    end else begin
      $display("%0d mismatching or unexpected results", mismatch_count);
      $display("tb_paged_bump_allocator: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d items queued, %0d results outstanding",
             pending_sizes.size(), expected_results.size());
    $display("tb_paged_bump_allocator: done, errors");
    $finish;
  end

endmodule
